### rtl/core/ntsu_pkg.sv
`default_nettype none

package ntsu_pkg;

  localparam int NTSU_MAX_ROWS     = 64;
  localparam int NTSU_MAX_NONLOCAL = 2;
  localparam int Q_W               = 32;
  localparam int IDX_W             = 6;
  localparam int FRAC_W            = 24;
  localparam int NREG_COLS         = 2;
  localparam int MIN_ROWS          = 3;
  localparam int DIV_W             = Q_W + FRAC_W;
  localparam int DIV_CNT_W         = 6;
  localparam int CFG_AW            = 5;

  localparam logic signed [Q_W-1:0] Q_MAX  = 32'sh7fffffff;
  localparam logic signed [Q_W-1:0] Q_MIN  = 32'sh80000000;
  localparam logic signed [63:0]    Q_HALF = 64'sd8388608;

  typedef enum logic [2:0] {
    REG_SYSTEM_SIZE = 3'd0,
    REG_NL_COUNT    = 3'd1,
    REG_NL_WEIGHT0  = 3'd2,
    REG_NL_WEIGHT1  = 3'd3,
    REG_NL_COL0     = 3'd4,
    REG_NL_COL1     = 3'd5
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_F_ADDR,
    S_F_LOAD,
    S_F_DEN,
    S_F_NUM,
    S_DIV,
    S_K_COL,
    S_K_RD,
    S_K_MUL,
    S_K_DIVGO,
    S_K_WR,
    S_Q_WR,
    S_B_ADDR,
    S_B_LOAD,
    S_B_ADD,
    S_B_COL,
    S_B_RD,
    S_B_MUL,
    S_B_KADD,
    S_B_OUT,
    S_B_WAIT
  } state_t;

  typedef enum logic [1:0] {
    DV_P,
    DV_Q,
    DV_K
  } div_op_t;

  function automatic logic signed [Q_W-1:0] qsat40(input logic signed [39:0] v);
    logic signed [Q_W-1:0] r;
    if (v > 40'sh007fffffff) r = Q_MAX;
    else if (v < -40'sh0080000000) r = Q_MIN;
    else r = v[Q_W-1:0];
    return r;
  endfunction

  function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] x,
                                                 input logic signed [Q_W-1:0] y);
    logic signed [63:0] pr;
    logic signed [63:0] sh;
    pr = x * y;
    pr = pr + Q_HALF;
    sh = pr >>> FRAC_W;
    return qsat40(sh[39:0]);
  endfunction

  function automatic logic signed [Q_W-1:0] qadd(input logic signed [Q_W-1:0] x,
                                                 input logic signed [Q_W-1:0] y);
    logic signed [Q_W:0] s;
    logic signed [Q_W-1:0] r;
    s = {x[Q_W-1], x} + {y[Q_W-1], y};
    if (s[Q_W] != s[Q_W-1]) r = s[Q_W] ? Q_MIN : Q_MAX;
    else r = s[Q_W-1:0];
    return r;
  endfunction

  function automatic logic signed [Q_W-1:0] qsub(input logic signed [Q_W-1:0] x,
                                                 input logic signed [Q_W-1:0] y);
    logic signed [Q_W:0] s;
    logic signed [Q_W-1:0] r;
    s = {x[Q_W-1], x} - {y[Q_W-1], y};
    if (s[Q_W] != s[Q_W-1]) r = s[Q_W] ? Q_MIN : Q_MAX;
    else r = s[Q_W-1:0];
    return r;
  endfunction

  function automatic logic signed [Q_W-1:0] qneg(input logic signed [Q_W-1:0] x);
    logic signed [Q_W-1:0] r;
    if (x == Q_MIN) r = Q_MAX;
    else r = -x;
    return r;
  endfunction

  function automatic logic [Q_W-1:0] qabs(input logic signed [Q_W-1:0] x);
    logic [Q_W-1:0] r;
    if (x[Q_W-1]) r = -x;
    else r = x;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ntsu_row_if.sv
`default_nettype none

interface ntsu_row_if
  import ntsu_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] sub_diag;
  logic signed [Q_W-1:0] main_diag;
  logic signed [Q_W-1:0] super_diag;
  logic signed [Q_W-1:0] rhs_value;
  logic                  row_last;

  modport source (output valid, sub_diag, main_diag, super_diag, rhs_value, row_last,
                  input ready);
  modport sink (input valid, sub_diag, main_diag, super_diag, rhs_value, row_last,
                output ready);
endinterface

`default_nettype wire

### rtl/core/ntsu_sol_if.sv
`default_nettype none

interface ntsu_sol_if
  import ntsu_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] solution_value;
  logic [IDX_W-1:0]      solution_index;
  logic                  solution_last;
  logic                  divide_fault;

  modport source (output valid, solution_value, solution_index, solution_last, divide_fault,
                  input ready);
  modport sink (input valid, solution_value, solution_index, solution_last, divide_fault,
                output ready);
endinterface

`default_nettype wire

### rtl/core/ntsu_ram.sv
`default_nettype none

module ntsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/nonlocal_tridiagonal_solver_unit.sv
`default_nettype none
// channel   dir  word                                     handshake
// in_row    in   sub, main, super diagonal, rhs, last      valid/ready
// out_sol   out  solution value, index, last, fault        valid/ready
// cfg       in   six registers at byte address 4*i         apb, pready tied high
//
// each row runs through one shared multiplier and one radix-2 divider; the final
// row is followed by the back substitution, whose words each wait while the sink
// holds ready low
// in_row.ready is high only while idle; rst_n clears control and configuration

module nonlocal_tridiagonal_solver_unit
  import ntsu_pkg::*;
#(
  parameter int MAX_ROWS     = NTSU_MAX_ROWS,
  parameter int MAX_NONLOCAL = NTSU_MAX_NONLOCAL
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  ntsu_row_if.sink               in_row,
  ntsu_sol_if.source             out_sol,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int IW   = $clog2(MAX_ROWS);
  localparam int KD   = MAX_NONLOCAL * MAX_ROWS;
  localparam int KAW  = $clog2(KD);
  localparam int CWA  = $clog2(MAX_ROWS + 1);
  localparam int CW   = (CWA > 7) ? CWA : 7;
  localparam int NC   = (MAX_NONLOCAL < NREG_COLS) ? MAX_NONLOCAL : NREG_COLS;

  // configuration
  logic [6:0]            size_r;
  logic [1:0]            nlcnt_r;
  logic signed [Q_W-1:0] w0_r, w1_r;
  logic [IDX_W-1:0]      col0_r, col1_r;
  reg_idx_t              widx;

  assign widx   = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= 7'(NTSU_MAX_ROWS);
      nlcnt_r <= '0;
      w0_r    <= '0;
      w1_r    <= '0;
      col0_r  <= '1;
      col1_r  <= '1;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_SYSTEM_SIZE: size_r  <= pwdata[6:0];
        REG_NL_COUNT:    nlcnt_r <= pwdata[1:0];
        REG_NL_WEIGHT0:  w0_r    <= pwdata;
        REG_NL_WEIGHT1:  w1_r    <= pwdata;
        REG_NL_COL0:     col0_r  <= pwdata[IDX_W-1:0];
        REG_NL_COL1:     col1_r  <= pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_SYSTEM_SIZE: prdata = 32'(size_r);
      REG_NL_COUNT:    prdata = 32'(nlcnt_r);
      REG_NL_WEIGHT0:  prdata = w0_r;
      REG_NL_WEIGHT1:  prdata = w1_r;
      REG_NL_COL0:     prdata = 32'(col0_r);
      REG_NL_COL1:     prdata = 32'(col1_r);
      default:         prdata = '0;
    endcase
  end

  // control and datapath registers
  state_t                state_r, state_nxt;
  logic [IW-1:0]         row_idx_r, row_idx_nxt;
  logic [IW-1:0]         r_r, r_nxt;
  logic                  fault_r, fault_nxt;
  logic                  final_r, final_nxt;
  logic [1:0]            ncols_r, ncols_nxt;
  logic [1:0]            s_r, s_nxt;
  logic signed [Q_W-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic signed [Q_W-1:0] den_r, den_nxt, prod_r, prod_nxt;
  logic signed [Q_W-1:0] pprev_r, pprev_nxt, qacc_r, qacc_nxt, t_r, t_nxt;
  logic signed [Q_W-1:0] xacc_r, xacc_nxt, xnext_r, xnext_nxt, pr_r, pr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [Q_W-1:0] out_value_r, out_value_nxt;
  logic [IDX_W-1:0]      out_index_r, out_index_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_fault_r, out_fault_nxt;

  // divider
  logic [DIV_W-1:0]      dv_quo_r, dv_quo_nxt;
  logic [Q_W-1:0]        dv_rem_r, dv_rem_nxt;
  logic [Q_W-1:0]        dv_den_r, dv_den_nxt;
  logic                  dv_neg_r, dv_neg_nxt;
  logic                  dv_zero_r, dv_zero_nxt;
  logic [DIV_CNT_W-1:0]  dv_cnt_r, dv_cnt_nxt;
  div_op_t               dv_op_r, dv_op_nxt;
  logic                  dv_start;
  logic signed [Q_W-1:0] dv_n, dv_d;
  logic [Q_W:0]          dv_sh, dv_diff;
  logic signed [Q_W-1:0] dv_res;

  // shared multiplier
  logic signed [Q_W-1:0] mul_a, mul_b, mul_res;

  // memories
  logic                  p_we, q_we, k_we, x_we;
  logic signed [Q_W-1:0] p_wd, q_wd, k_wd, x_wd;
  logic [KAW-1:0]        k_waddr, k_raddr;
  logic [IW-1:0]         x_raddr;
  logic [Q_W-1:0]        p_rd, q_rd, k_rd, x_rd;

  // derived values
  logic [CW-1:0]         n_eff, size_ext, i1, r1, e_ext;
  logic [1:0]            ncols_now;
  logic signed [Q_W-1:0] w_sel;
  logic [IDX_W-1:0]      col_sel;
  logic                  in_acc, out_acc;

  assign in_acc  = in_row.valid && in_row.ready;
  assign out_acc = out_valid_r && out_sol.ready;

  assign size_ext  = CW'(size_r);
  assign n_eff     = (size_ext < CW'(MIN_ROWS)) ? CW'(MIN_ROWS) :
                     (size_ext > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : size_ext;
  assign ncols_now = (nlcnt_r > 2'(NC)) ? 2'(NC) : nlcnt_r;
  assign i1        = CW'(row_idx_r) + CW'(1);
  assign r1        = CW'(r_r) + CW'(1);
  assign w_sel     = s_r[0] ? w1_r : w0_r;
  assign col_sel   = s_r[0] ? col1_r : col0_r;
  assign e_ext     = CW'(col_sel);

  assign k_waddr = KAW'(KAW'(s_r) * KAW'(MAX_ROWS) + KAW'(row_idx_r));
  assign k_raddr = KAW'(KAW'(s_r) * KAW'(MAX_ROWS) + KAW'(r_r));
  assign x_raddr = IW'(col_sel);

  // operand select for the one multiplier
  always_comb begin
    mul_a = a_r;
    mul_b = '0;
    unique case (state_r)
      S_F_LOAD: mul_b = q_rd;
      S_F_DEN:  mul_b = pprev_r;
      S_K_MUL:  mul_b = k_rd;
      S_B_LOAD: begin
        mul_a = q_rd;
        mul_b = xnext_r;
      end
      S_B_MUL: begin
        mul_a = k_rd;
        mul_b = (e_ext < i1) ? x_rd : '0;
      end
      default: ;
    endcase
  end

  assign mul_res = qmul(mul_a, mul_b);

  // one restoring step and the signed, saturated quotient
  assign dv_sh   = {dv_rem_r, dv_quo_r[DIV_W-1]};
  assign dv_diff = dv_sh - {1'b0, dv_den_r};

  always_comb begin
    if (dv_zero_r) dv_res = '0;
    else if (dv_neg_r) begin
      if (dv_quo_r > DIV_W'(33'h080000000)) dv_res = Q_MIN;
      else dv_res = -Q_W'(dv_quo_r);
    end else begin
      if (dv_quo_r > DIV_W'(32'h7fffffff)) dv_res = Q_MAX;
      else dv_res = Q_W'(dv_quo_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    row_idx_nxt   = row_idx_r;
    r_nxt         = r_r;
    fault_nxt     = fault_r;
    final_nxt     = final_r;
    ncols_nxt     = ncols_r;
    s_nxt         = s_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    den_nxt       = den_r;
    prod_nxt      = prod_r;
    pprev_nxt     = pprev_r;
    qacc_nxt      = qacc_r;
    t_nxt         = t_r;
    xacc_nxt      = xacc_r;
    xnext_nxt     = xnext_r;
    pr_nxt        = pr_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    out_fault_nxt = out_fault_r;
    dv_quo_nxt    = dv_quo_r;
    dv_rem_nxt    = dv_rem_r;
    dv_den_nxt    = dv_den_r;
    dv_neg_nxt    = dv_neg_r;
    dv_zero_nxt   = dv_zero_r;
    dv_cnt_nxt    = dv_cnt_r;
    dv_op_nxt     = dv_op_r;
    dv_start      = 1'b0;
    dv_n          = '0;
    dv_d          = '0;
    p_we          = 1'b0;
    q_we          = 1'b0;
    k_we          = 1'b0;
    x_we          = 1'b0;
    p_wd          = dv_res;
    q_wd          = qacc_r;
    k_wd          = '0;
    x_wd          = xacc_r;
    in_row.ready  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_row.ready = 1'b1;
        if (in_acc) begin
          a_nxt     = in_row.sub_diag;
          b_nxt     = in_row.main_diag;
          c_nxt     = in_row.super_diag;
          d_nxt     = in_row.rhs_value;
          final_nxt = in_row.row_last || (i1 >= n_eff);
          ncols_nxt = ncols_now;
          r_nxt     = row_idx_r - IW'(1);
          if (row_idx_r == '0) begin
            den_nxt   = in_row.main_diag;
            dv_start  = 1'b1;
            dv_n      = in_row.rhs_value;
            dv_d      = in_row.main_diag;
            dv_op_nxt = DV_P;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_F_ADDR;
          end
        end
      end
      S_F_ADDR: state_nxt = S_F_LOAD;
      S_F_LOAD: begin
        pprev_nxt = p_rd;
        prod_nxt  = mul_res;
        state_nxt = S_F_DEN;
      end
      S_F_DEN: begin
        den_nxt   = qadd(b_r, prod_r);
        prod_nxt  = mul_res;
        state_nxt = S_F_NUM;
      end
      S_F_NUM: begin
        dv_start  = 1'b1;
        dv_n      = qsub(d_r, prod_r);
        dv_d      = den_r;
        dv_op_nxt = DV_P;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dv_cnt_r == '0) begin
          unique case (dv_op_r)
            DV_P: begin
              p_we = 1'b1;
              if (final_r) begin
                qacc_nxt  = '0;
                s_nxt     = '0;
                state_nxt = S_K_COL;
              end else begin
                dv_start  = 1'b1;
                dv_n      = c_r;
                dv_d      = den_r;
                dv_op_nxt = DV_Q;
              end
            end
            DV_Q: begin
              qacc_nxt  = qneg(dv_res);
              s_nxt     = '0;
              state_nxt = S_K_COL;
            end
            DV_K: begin
              t_nxt     = qneg(dv_res);
              state_nxt = S_K_WR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_K_COL: begin
        priority if (s_r >= ncols_r) begin
          state_nxt = S_Q_WR;
        end else if (final_r) begin
          t_nxt     = '0;
          state_nxt = S_K_WR;
        end else if (row_idx_r == '0) begin
          dv_start  = 1'b1;
          dv_n      = w_sel;
          dv_d      = den_r;
          dv_op_nxt = DV_K;
          state_nxt = S_DIV;
        end else if (i1 <= e_ext) begin
          state_nxt = S_K_RD;
        end else begin
          t_nxt     = '0;
          state_nxt = S_K_WR;
        end
      end
      S_K_RD: state_nxt = S_K_MUL;
      S_K_MUL: begin
        prod_nxt  = mul_res;
        state_nxt = S_K_DIVGO;
      end
      S_K_DIVGO: begin
        dv_start  = 1'b1;
        dv_n      = prod_r;
        dv_d      = den_r;
        dv_op_nxt = DV_K;
        state_nxt = S_DIV;
      end
      S_K_WR: begin
        k_we = 1'b1;
        if (final_r) k_wd = '0;
        else if (row_idx_r == '0) k_wd = t_r;
        else begin
          k_wd = (i1 < e_ext) ? t_r : '0;
          if (i1 == e_ext) qacc_nxt = qadd(qacc_r, t_r);
        end
        s_nxt     = s_r + 2'd1;
        state_nxt = S_K_COL;
      end
      S_Q_WR: begin
        q_we = 1'b1;
        if (final_r) begin
          r_nxt     = row_idx_r;
          state_nxt = S_B_ADDR;
        end else begin
          row_idx_nxt = row_idx_r + IW'(1);
          state_nxt   = S_IDLE;
        end
      end
      S_B_ADDR: state_nxt = S_B_LOAD;
      S_B_LOAD: begin
        if (r_r == row_idx_r) begin
          xacc_nxt  = p_rd;
          state_nxt = S_B_OUT;
        end else begin
          pr_nxt    = p_rd;
          prod_nxt  = mul_res;
          state_nxt = S_B_ADD;
        end
      end
      S_B_ADD: begin
        xacc_nxt  = qadd(pr_r, prod_r);
        s_nxt     = '0;
        state_nxt = S_B_COL;
      end
      S_B_COL: begin
        priority if (s_r >= ncols_r) state_nxt = S_B_OUT;
        else if (r1 <= e_ext) state_nxt = S_B_RD;
        else s_nxt = s_r + 2'd1;
      end
      S_B_RD: state_nxt = S_B_MUL;
      S_B_MUL: begin
        prod_nxt  = mul_res;
        state_nxt = S_B_KADD;
      end
      S_B_KADD: begin
        xacc_nxt  = qadd(xacc_r, prod_r);
        s_nxt     = s_r + 2'd1;
        state_nxt = S_B_COL;
      end
      S_B_OUT: begin
        x_we          = 1'b1;
        xnext_nxt     = xacc_r;
        out_valid_nxt = 1'b1;
        out_value_nxt = xacc_r;
        out_index_nxt = IDX_W'(r_r);
        out_last_nxt  = (r_r == '0);
        out_fault_nxt = fault_r;
        state_nxt     = S_B_WAIT;
      end
      S_B_WAIT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (r_r == '0) begin
            row_idx_nxt = '0;
            fault_nxt   = 1'b0;
            state_nxt   = S_IDLE;
          end else begin
            r_nxt     = r_r - IW'(1);
            state_nxt = S_B_ADDR;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // divider load or step
    if (dv_start) begin
      dv_quo_nxt  = {qabs(dv_n), FRAC_W'(0)};
      dv_rem_nxt  = '0;
      dv_den_nxt  = qabs(dv_d);
      dv_neg_nxt  = dv_n[Q_W-1] ^ dv_d[Q_W-1];
      dv_zero_nxt = (dv_d == '0);
      dv_cnt_nxt  = DIV_CNT_W'(DIV_W);
      if (dv_d == '0) fault_nxt = 1'b1;
    end else if (state_r == S_DIV && dv_cnt_r != '0) begin
      dv_cnt_nxt = dv_cnt_r - DIV_CNT_W'(1);
      if (!dv_diff[Q_W]) begin
        dv_rem_nxt = dv_diff[Q_W-1:0];
        dv_quo_nxt = {dv_quo_r[DIV_W-2:0], 1'b1};
      end else begin
        dv_rem_nxt = dv_sh[Q_W-1:0];
        dv_quo_nxt = {dv_quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_idx_r   <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
      dv_cnt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      row_idx_r   <= row_idx_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
      dv_cnt_r    <= dv_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r         <= r_nxt;
    final_r     <= final_nxt;
    ncols_r     <= ncols_nxt;
    s_r         <= s_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    c_r         <= c_nxt;
    d_r         <= d_nxt;
    den_r       <= den_nxt;
    prod_r      <= prod_nxt;
    pprev_r     <= pprev_nxt;
    qacc_r      <= qacc_nxt;
    t_r         <= t_nxt;
    xacc_r      <= xacc_nxt;
    xnext_r     <= xnext_nxt;
    pr_r        <= pr_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
    out_fault_r <= out_fault_nxt;
    dv_quo_r    <= dv_quo_nxt;
    dv_rem_r    <= dv_rem_nxt;
    dv_den_r    <= dv_den_nxt;
    dv_neg_r    <= dv_neg_nxt;
    dv_zero_r   <= dv_zero_nxt;
    dv_op_r     <= dv_op_nxt;
  end

  ntsu_ram #(.WIDTH(Q_W), .DEPTH(MAX_ROWS)) u_p_ram (
    .clk     (clk),
    .wr_en   (p_we),
    .wr_addr (row_idx_r),
    .wr_data (p_wd),
    .rd_addr (r_r),
    .rd_data (p_rd)
  );

  ntsu_ram #(.WIDTH(Q_W), .DEPTH(MAX_ROWS)) u_q_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (row_idx_r),
    .wr_data (q_wd),
    .rd_addr (r_r),
    .rd_data (q_rd)
  );

  ntsu_ram #(.WIDTH(Q_W), .DEPTH(KD)) u_k_ram (
    .clk     (clk),
    .wr_en   (k_we),
    .wr_addr (k_waddr),
    .wr_data (k_wd),
    .rd_addr (k_raddr),
    .rd_data (k_rd)
  );

  ntsu_ram #(.WIDTH(Q_W), .DEPTH(MAX_ROWS)) u_x_ram (
    .clk     (clk),
    .wr_en   (x_we),
    .wr_addr (r_r),
    .wr_data (x_wd),
    .rd_addr (x_raddr),
    .rd_data (x_rd)
  );

  assign out_sol.valid          = out_valid_r;
  assign out_sol.solution_value = out_value_r;
  assign out_sol.solution_index = out_index_r;
  assign out_sol.solution_last  = out_last_r;
  assign out_sol.divide_fault   = out_fault_r;

endmodule

`default_nettype wire

### sim/nonlocal_tridiagonal_solver_unit_test.sv
module nonlocal_tridiagonal_solver_unit_test;
  import ntsu_pkg::*;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic [5:0]         idx;
    logic               last;
    logic               fault;
  } sol_t;

  typedef struct {
    q_t   a, b, c, d;
    logic last;
    logic chk;
    q_t   x0;
    logic f0;
  } row_vec_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ntsu_row_if row_ch ();
  ntsu_sol_if sol_ch ();

  nonlocal_tridiagonal_solver_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_row  (row_ch.sink),
    .out_sol (sol_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow configuration and sweep state
  int unsigned sz_r, cnt_r;
  q_t wt_r [2];
  int unsigned col_r [2];
  q_t p_m [64];
  q_t q_m [64];
  q_t k_m [2][64];
  q_t x_m [64];
  int unsigned rows_done;
  bit fault_m;

  sol_t solutions_due [$];
  int fails, words_seen, rows_sent, solves;
  longint cycles;
  bit sink_stall_on;
  int unsigned sink_wait;
  bit done_flag;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic q_t sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return q_t'(v);
  endfunction

  function automatic q_t m_add(q_t x, q_t y);
    return sat(longint'(x) + longint'(y));
  endfunction

  function automatic q_t m_sub(q_t x, q_t y);
    return sat(longint'(x) - longint'(y));
  endfunction

  function automatic q_t m_neg(q_t x);
    return sat(-longint'(x));
  endfunction

  function automatic q_t m_mul(q_t x, q_t y);
    longint v;
    v = longint'(x) * longint'(y) + 64'sd8388608;
    return sat(v >>> 24);
  endfunction

  function automatic q_t m_div(q_t n, q_t dn);
    longint num;
    if (dn == 0) begin
      fault_m = 1;
      return 0;
    end
    num = longint'(n) * 64'sd16777216;
    return sat(num / longint'(dn));
  endfunction

  task automatic predict_row(q_t a, q_t b, q_t c, q_t d, logic lst);
    int unsigned n, i, nc, m, e;
    bit fin;
    q_t den, q, t, x, xe;
    n = sz_r < 3 ? 3 : (sz_r > 64 ? 64 : sz_r);
    nc = cnt_r > 2 ? 2 : cnt_r;
    i = rows_done;
    fin = lst || (i + 1 >= n);
    if (i == 0) begin
      p_m[0] = m_div(d, b);
      q_m[0] = fin ? 0 : m_neg(m_div(c, b));
      for (int s = 0; s < nc; s++) k_m[s][0] = fin ? 0 : m_neg(m_div(wt_r[s], b));
    end else begin
      den = m_add(b, m_mul(a, q_m[i-1]));
      p_m[i] = m_div(m_sub(d, m_mul(a, p_m[i-1])), den);
      if (fin) begin
        q_m[i] = 0;
        for (int s = 0; s < nc; s++) k_m[s][i] = 0;
      end else begin
        q = m_neg(m_div(c, den));
        for (int s = 0; s < nc; s++) begin
          e = col_r[s];
          t = 0;
          if (i + 1 <= e) t = m_neg(m_div(m_mul(a, k_m[s][i-1]), den));
          k_m[s][i] = (i + 1 < e) ? t : 0;
          if (i + 1 == e) q = m_add(q, t);
        end
        q_m[i] = q;
      end
    end
    if (!fin) begin
      rows_done = i + 1;
      return;
    end
    m = i + 1;
    for (int r = m - 1; r >= 0; r--) begin
      if (r == m - 1) x = p_m[r];
      else begin
        x = m_add(p_m[r], m_mul(q_m[r], x_m[r+1]));
        for (int s = 0; s < nc; s++) begin
          e = col_r[s];
          if (r + 1 <= e) begin
            xe = (e < m) ? x_m[e] : 0;
            x = m_add(x, m_mul(k_m[s][r], xe));
          end
        end
      end
      x_m[r] = x;
      solutions_due.push_back('{x, 6'(r), r == 0, fault_m});
    end
    rows_done = 0;
    fault_m = 0;
    solves++;
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= CFG_AW'(int'(r) * 4); pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (r)
      REG_SYSTEM_SIZE: sz_r = v[6:0];
      REG_NL_COUNT:    cnt_r = v[1:0];
      REG_NL_WEIGHT0:  wt_r[0] = v;
      REG_NL_WEIGHT1:  wt_r[1] = v;
      REG_NL_COL0:     col_r[0] = v[5:0];
      REG_NL_COL1:     col_r[1] = v[5:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (solutions_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_row(q_t a, q_t b, q_t c, q_t d, logic lst);
    repeat ($urandom_range(0, 13) * ($urandom_range(0, 3) != 0)) @(posedge clk);
    row_ch.valid <= 1;
    row_ch.sub_diag <= a; row_ch.main_diag <= b;
    row_ch.super_diag <= c; row_ch.rhs_value <= d; row_ch.row_last <= lst;
    @(posedge clk);
    while (!row_ch.ready) @(posedge clk);
    row_ch.valid <= 0;
    predict_row(a, b, c, d, lst);
    rows_sent++;
    @(posedge clk);
  endtask

  function automatic q_t rnd_q();
    case ($urandom_range(0, 5))
      0: return q_t'($urandom());
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return q_t'(int'($urandom_range(0, 32'h04000000)) - 32'sh02000000);
    endcase
  endfunction

  // sink side with a drawn wait before each word while sink stalling is on
  always @(posedge clk) begin
    sol_t got, want;
    int unsigned w;
    if (!rst_n) begin
      sol_ch.ready <= 0;
      sink_wait <= 0;
    end else if (sol_ch.valid && sol_ch.ready) begin
      got = '{sol_ch.solution_value, sol_ch.solution_index, sol_ch.solution_last,
              sol_ch.divide_fault};
      words_seen++;
      if (solutions_due.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected word %p", got);
      end else begin
        want = solutions_due.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
      w = sink_stall_on ? $urandom_range(0, 13) : 0;
      sink_wait <= w;
      sol_ch.ready <= (w == 0);
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      sol_ch.ready <= (sink_wait == 1);
    end else begin
      sol_ch.ready <= 1'b1;
    end
  end

  row_vec_t dir_rows [$];

  initial begin
    q_t one, big;
    int unsigned n;
    one = 32'sh01000000;
    big = 32'sh7fffffff;
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    row_ch.valid = 0; row_ch.sub_diag = 0; row_ch.main_diag = 0;
    row_ch.super_diag = 0; row_ch.rhs_value = 0; row_ch.row_last = 0;
    sol_ch.ready = 0;
    fails = 0; words_seen = 0; rows_sent = 0; solves = 0; cycles = 0;
    sink_stall_on = 0;
    sz_r = 64; cnt_r = 0; wt_r[0] = 0; wt_r[1] = 0; col_r[0] = 63; col_r[1] = 63;
    rows_done = 0; fault_m = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single row solve after reset: x0 = d/b, zero divisor faults
    dir_rows.push_back('{0, one, 0, 32'sh02000000, 1, 1, 32'sh02000000, 0});
    dir_rows.push_back('{0, 0, 0, one, 1, 1, 0, 1});
    dir_rows.push_back('{0, one, 0, big, 1, 1, big, 0});
    dir_rows.push_back('{0, 32'sh00800000, 0, big, 1, 1, big, 0});
    dir_rows.push_back('{0, one, 0, 32'sh80000000, 1, 1, 32'sh80000000, 0});
    // short systems with extremes
    dir_rows.push_back('{big, big, big, big, 0, 0, 0, 0});
    dir_rows.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0});
    dir_rows.push_back('{one, 0, one, one, 1, 0, 0, 0});
    dir_rows.push_back('{-1, 1, -1, 1, 0, 0, 0, 0});
    dir_rows.push_back('{one, 32'sh02000000, one, one, 1, 0, 0, 0});
    foreach (dir_rows[j]) begin
      send_row(dir_rows[j].a, dir_rows[j].b, dir_rows[j].c, dir_rows[j].d, dir_rows[j].last);
      if (dir_rows[j].chk) begin
        if (solutions_due.size() != 1 || solutions_due[0].val !== dir_rows[j].x0 ||
            solutions_due[0].fault !== dir_rows[j].f0) begin
          fails++;
          if (fails <= 10) $display("row %0d: predictor disagrees with table", j);
        end
      end
    end
    drain();

    // size clamps and nonlocal settings, size limit ends the solve
    write_reg(REG_SYSTEM_SIZE, 0);
    write_reg(REG_NL_COUNT, 3);
    write_reg(REG_NL_WEIGHT0, 32'h80000000);
    write_reg(REG_NL_WEIGHT1, 32'h7fffffff);
    write_reg(REG_NL_COL0, 0);
    write_reg(REG_NL_COL1, 1);
    for (int j = 0; j < 3; j++) send_row(one, 32'sh04000000, one, one, 0);
    drain();
    write_reg(REG_SYSTEM_SIZE, 127);
    write_reg(REG_NL_COUNT, 2);
    write_reg(REG_NL_COL0, 63);
    write_reg(REG_NL_COL1, 2);
    write_reg(REG_NL_WEIGHT0, 32'h00400000);
    for (int j = 0; j < 64; j++) send_row(rnd_q(), rnd_q(), rnd_q(), rnd_q(), 0);
    drain();

    // random solves, mostly small sizes
    sink_stall_on = 1;
    while (rows_sent < 500) begin
      if ($urandom_range(0, 3) == 0) sink_stall_on = ~sink_stall_on;
      write_reg(REG_SYSTEM_SIZE, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                              : $urandom_range(3, 10));
      write_reg(REG_NL_COUNT, $urandom_range(0, 3));
      write_reg(REG_NL_WEIGHT0, $urandom_range(0, 1) ? $urandom() : rnd_q());
      write_reg(REG_NL_WEIGHT1, rnd_q());
      write_reg(REG_NL_COL0, $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(1, 8));
      write_reg(REG_NL_COL1, $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(1, 8));
      n = sz_r < 3 ? 3 : (sz_r > 64 ? 64 : sz_r);
      for (int j = 0; j < n; j++) begin
        if ($urandom_range(0, 1))
          send_row(rnd_q(), 32'sh04000000 + q_t'($urandom_range(0, 32'h01000000)),
                   rnd_q(), rnd_q(), $urandom_range(0, 15) == 0);
        else
          send_row(rnd_q(), ($urandom_range(0, 15) == 0) ? 0 : rnd_q(), rnd_q(), rnd_q(),
                   $urandom_range(0, 15) == 0);
        if (rows_done == 0) break;
      end
      drain();
    end

    drain();
    $display("%0d rows over %0d solves, %0d words checked, %0d mismatches",
             rows_sent, solves, words_seen, fails);
    if (fails == 0 && solutions_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/ntsu_pkg.sv
rtl/core/ntsu_row_if.sv
rtl/core/ntsu_sol_if.sv
rtl/core/ntsu_ram.sv
rtl/core/nonlocal_tridiagonal_solver_unit.sv
sim/nonlocal_tridiagonal_solver_unit_test.sv
